[design/lcdt_pkg.sv]
// Package for the LCD line timing and STAT interrupt unit.
// Holds the timing constants, mode codes and item/state types.
// No dependencies.
package lcdt_pkg;

  localparam int unsigned DotsPerLine  = 456;
  localparam int unsigned VisibleLines = 144;
  localparam int unsigned VblankLines  = 10;
  localparam int unsigned OamDots      = 80;
  localparam int unsigned XferDots     = 172;

  // Mode codes as read back in STAT.
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  // Bit positions in stat_enables.
  localparam int unsigned EnHblank = 0;
  localparam int unsigned EnVblank = 1;
  localparam int unsigned EnOam    = 2;
  localparam int unsigned EnCoinc  = 3;

  typedef struct packed {
    logic [3:0] stat_enables;
    logic [7:0] compare_line;
    logic       lcd_on;
    logic [7:0] cycles;
  } in_item_t;

  typedef struct packed {
    logic [7:0] render_line;
    logic       render_valid;
    logic       vblank_irq;
    logic       stat_irq;
    logic       coincidence;
    logic [1:0] lcd_mode;
    logic [7:0] line;
  } out_item_t;

  typedef struct packed {
    logic [8:0] dot_count;
    logic [7:0] line_count;
    logic       stat_level;
    logic       coincidence_flag;
  } timing_state_t;

endpackage

[design/lcdt_step.sv]
// One timing step: dot/line advance, mode decode, coincidence and STAT edge.
// Pure combinational; depends on lcdt_pkg.
module lcdt_step (
  input  lcdt_pkg::timing_state_t state_cur,
  input  lcdt_pkg::in_item_t      item,
  output lcdt_pkg::timing_state_t state_nxt,
  output lcdt_pkg::out_item_t     result
);

  localparam logic [9:0] DotsLine  = 10'(lcdt_pkg::DotsPerLine);
  localparam logic [7:0] VisLine   = 8'(lcdt_pkg::VisibleLines);
  localparam logic [7:0] LastLine  = 8'(lcdt_pkg::VisibleLines + lcdt_pkg::VblankLines);
  localparam logic [8:0] OamEnd    = 9'(lcdt_pkg::OamDots);
  localparam logic [8:0] XferEnd   = 9'(lcdt_pkg::OamDots + lcdt_pkg::XferDots);

  logic [9:0] dot_sum;
  logic       wrap;
  logic [8:0] dot_new;
  logic [7:0] line_new;
  logic       coinc_new;
  logic [1:0] mode;
  logic       level;

  always_comb begin
    dot_sum = {1'b0, state_cur.dot_count} + {2'b00, item.cycles};
    wrap    = (dot_sum >= DotsLine);
    dot_new = wrap ? 9'(dot_sum - DotsLine) : dot_sum[8:0];

    line_new = state_cur.line_count;
    if (wrap) begin
      if (state_cur.line_count >= LastLine) begin
        // Drop leftover dots when the frame wraps.
        line_new = '0;
        dot_new  = '0;
      end else begin
        line_new = state_cur.line_count + 8'd1;
      end
    end

    coinc_new = (line_new == item.compare_line);

    if (line_new >= VisLine) begin
      mode = lcdt_pkg::MODE_VBLANK;
    end else if (dot_new < OamEnd) begin
      mode = lcdt_pkg::MODE_OAM;
    end else if (dot_new < XferEnd) begin
      mode = lcdt_pkg::MODE_XFER;
    end else begin
      mode = lcdt_pkg::MODE_HBLANK;
    end

    level = (item.stat_enables[lcdt_pkg::EnCoinc]  && coinc_new) ||
            (item.stat_enables[lcdt_pkg::EnOam]    && mode == lcdt_pkg::MODE_OAM) ||
            (item.stat_enables[lcdt_pkg::EnVblank] && mode == lcdt_pkg::MODE_VBLANK) ||
            (item.stat_enables[lcdt_pkg::EnHblank] && mode == lcdt_pkg::MODE_HBLANK);

    if (item.lcd_on) begin
      state_nxt.dot_count        = dot_new;
      state_nxt.line_count       = line_new;
      state_nxt.stat_level       = level;
      state_nxt.coincidence_flag = coinc_new;

      result.line         = line_new;
      result.lcd_mode     = mode;
      result.coincidence  = coinc_new;
      result.stat_irq     = level && !state_cur.stat_level;
      result.vblank_irq   = (line_new == VisLine);
      result.render_valid = wrap && (state_cur.line_count < VisLine);
      result.render_line  = (wrap && (state_cur.line_count < VisLine)) ?
                            state_cur.line_count : 8'd0;
    end else begin
      // Display off: force line to zero, hold everything else.
      state_nxt            = state_cur;
      state_nxt.line_count = '0;

      result              = '0;
      result.lcd_mode     = lcdt_pkg::MODE_HBLANK;
      result.coincidence  = state_cur.coincidence_flag;
    end
  end

endmodule

[design/lcd_line_timing_and_stat_irq_unit.sv]
// Top level of the LCD line timing and STAT interrupt unit.
// Input register, step logic (lcdt_step) and result register with the timing state.
// Depends on lcdt_pkg and lcdt_step.
//
// Usage:
//   Each input transaction on the in_ channel carries the dot cycles elapsed
//   since the previous one, the display enable, the compare line and the four
//   STAT source enables. Every input transaction produces exactly one result
//   transaction on the out_ channel with the line, mode, coincidence flag,
//   STAT and VBlank interrupt requests and an optional render request.
//
//   An accepted transaction is registered in the input register, then stepped
//   into the result register, from where its result is offered. Throughput is
//   one transaction per cycle while out_tready stays high; the only loop is the
//   update of the dot/line/STAT state held with the result register.
//
//   Stall: while out_tready is low the result register holds, the input
//   register fills once more, then in_tready drops. No transaction is lost.
//
//   Reset (rst_n low, synchronous): both stage valids clear and the timing
//   state returns to dot 0, line 0, STAT level 0 and coincidence 0.
module lcd_line_timing_and_stat_irq_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] cycles, [8] lcd_on, [16:9] compare_line, [20:17] stat_enables, [23:21] zero
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] line, [9:8] lcd_mode, [10] coincidence, [11] stat_irq, [12] vblank_irq,
  // [13] render_valid, [21:14] render_line, [23:22] zero
  output logic [23:0] out_tdata
);

  // Input stage.
  logic                    in_valid_r;
  lcdt_pkg::in_item_t      in_item_r;
  // Result stage and timing state.
  logic                    out_valid_r;
  lcdt_pkg::out_item_t     out_item_r;
  lcdt_pkg::timing_state_t state_r;

  lcdt_pkg::timing_state_t state_nxt;
  lcdt_pkg::out_item_t     result_nxt;
  logic                    step_go;
  logic                    in_take;

  // Advance an item into the result stage when the result slot is free or drains.
  assign step_go   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step_go;
  assign in_take   = in_tvalid && in_tready;

  lcdt_step u_step (
    .state_cur (state_r),
    .item      (in_item_r),
    .state_nxt (state_nxt),
    .result    (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (step_go) begin
        in_valid_r <= 1'b0;
      end

      if (step_go) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_tdata[20:0];
    end
    if (step_go) begin
      out_item_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_item_r};

  // Result line never leaves the frame.
  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_item_r.line <= 8'(lcdt_pkg::VisibleLines + lcdt_pkg::VblankLines))
    else $error("line out of range");

  // VBlank mode exactly on lines 144 and above.
  a_vblank_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_item_r.line >= 8'(lcdt_pkg::VisibleLines)) ==
                     (out_item_r.lcd_mode == lcdt_pkg::MODE_VBLANK)))
    else $error("mode disagrees with line");

  // A render request names a visible line, one before the current line.
  a_render_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.render_valid |->
      out_item_r.render_line < 8'(lcdt_pkg::VisibleLines) &&
      out_item_r.line == out_item_r.render_line + 8'd1)
    else $error("bad render request");

  // VBlank request only on line 144.
  a_vblank_irq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.vblank_irq |-> out_item_r.line == 8'(lcdt_pkg::VisibleLines))
    else $error("vblank irq off line 144");

  // State only moves when an item is stepped.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step_go |=> $stable(state_r))
    else $error("state changed without a step");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for lcd_line_timing_and_stat_irq_unit.
// Drives step transactions on the in_ stream and checks every out_ result
// against a cycle-free model of the dot/line/STAT timing. Depends on lcdt_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Timing model plus the queue of results it still waits for.
  class line_timing_tracker;
    logic [8:0] dot_q;
    logic [7:0] line_q;
    logic       stat_q;
    logic       coinc_q;
    lcdt_pkg::out_item_t pending_results[$];
    int unsigned errors;
    int unsigned steps, renders, vblank_steps, stat_pulses, frame_wraps, off_steps;

    function new();
      dot_q = '0;
      line_q = '0;
      stat_q = 1'b0;
      coinc_q = 1'b0;
      errors = 0;
      steps = 0;
      renders = 0;
      vblank_steps = 0;
      stat_pulses = 0;
      frame_wraps = 0;
      off_steps = 0;
    endfunction

    // Advance the timing model by one accepted step and queue its result.
    function void accept_step(lcdt_pkg::in_item_t it);
      lcdt_pkg::out_item_t r;
      logic [1:0]  mode;
      logic        lvl;
      int unsigned dots;
      r = '0;
      steps++;
      if (!it.lcd_on) begin
        // Display off: line forced to zero, dots, STAT level and flag held.
        line_q = '0;
        r.coincidence = coinc_q;
        off_steps++;
      end else begin
        dots = dot_q + it.cycles;
        if (dots >= lcdt_pkg::DotsPerLine) begin
          dots -= lcdt_pkg::DotsPerLine;
          if (line_q < lcdt_pkg::VisibleLines) begin
            r.render_valid = 1'b1;
            r.render_line = line_q;
          end
          // Last line wraps to zero and drops the leftover dots.
          if (line_q >= lcdt_pkg::VisibleLines + lcdt_pkg::VblankLines) begin
            line_q = '0;
            dots = 0;
            frame_wraps++;
          end else begin
            line_q = line_q + 8'd1;
          end
        end
        dot_q = 9'(dots);
        r.vblank_irq = (line_q == lcdt_pkg::VisibleLines);
        coinc_q = (line_q == it.compare_line);
        if (line_q >= lcdt_pkg::VisibleLines) mode = lcdt_pkg::MODE_VBLANK;
        else if (dot_q < lcdt_pkg::OamDots) mode = lcdt_pkg::MODE_OAM;
        else if (dot_q < lcdt_pkg::OamDots + lcdt_pkg::XferDots) mode = lcdt_pkg::MODE_XFER;
        else mode = lcdt_pkg::MODE_HBLANK;
        lvl = (it.stat_enables[lcdt_pkg::EnCoinc] && coinc_q)
           || (it.stat_enables[lcdt_pkg::EnOam] && mode == lcdt_pkg::MODE_OAM)
           || (it.stat_enables[lcdt_pkg::EnVblank] && mode == lcdt_pkg::MODE_VBLANK)
           || (it.stat_enables[lcdt_pkg::EnHblank] && mode == lcdt_pkg::MODE_HBLANK);
        r.stat_irq = lvl && !stat_q;
        stat_q = lvl;
        r.line = line_q;
        r.lcd_mode = mode;
        r.coincidence = coinc_q;
        renders += r.render_valid;
        vblank_steps += r.vblank_irq;
        stat_pulses += r.stat_irq;
      end
      pending_results.push_back(r);
    endfunction

    function void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
      if (exp_v !== got_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void compare_result(lcdt_pkg::out_item_t got);
      lcdt_pkg::out_item_t exp_r;
      if (pending_results.size() == 0) begin
        $error("result transaction with no step waiting: %h", got);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("line", exp_r.line, got.line);
        check_field("lcd_mode", exp_r.lcd_mode, got.lcd_mode);
        check_field("coincidence", exp_r.coincidence, got.coincidence);
        check_field("stat_irq", exp_r.stat_irq, got.stat_irq);
        check_field("vblank_irq", exp_r.vblank_irq, got.vblank_irq);
        check_field("render_valid", exp_r.render_valid, got.render_valid);
        check_field("render_line", exp_r.render_line, got.render_line);
      end
    endfunction
  endclass

  localparam int unsigned RandomSteps = 1330;
  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned LongHold    = 64;
  localparam int unsigned DrainCycles = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // [7:0] cycles, [8] lcd_on, [16:9] compare_line, [20:17] stat_enables
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [7:0] line, [9:8] lcd_mode, [10] coincidence, [11] stat_irq,
                                // [12] vblank_irq, [13] render_valid, [21:14] render_line

  line_timing_tracker tracker = new();
  bit          gaps_on = 1'b1;  // clear for stretches with no idling on either side
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;

  always #1 clk = ~clk;

  lcd_line_timing_and_stat_irq_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  function automatic lcdt_pkg::in_item_t make_step(logic [7:0] cyc, logic on, logic [7:0] cmp,
                                                   logic [3:0] en);
    lcdt_pkg::in_item_t it;
    it.cycles = cyc;
    it.lcd_on = on;
    it.compare_line = cmp;
    it.stat_enables = en;
    return it;
  endfunction

  // Mostly large dot counts so several frames pass; compare lines track the
  // current line often enough to hit coincidence. Drop the display now and
  // then, early as noise and later late in vblank to cut some frames short.
  function automatic lcdt_pkg::in_item_t random_step(int unsigned idx);
    lcdt_pkg::in_item_t it;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) it.cycles = 8'($urandom_range(0, 255));
    else if (pick == 1) it.cycles = 8'($urandom_range(0, 15));
    else it.cycles = 8'($urandom_range(150, 255));
    if (idx < 100) it.lcd_on = ($urandom_range(0, 24) != 0);
    else if (tracker.line_q >= 150 && tracker.line_q <= 153)
      it.lcd_on = ($urandom_range(0, 39) != 0);
    else it.lcd_on = 1'b1;
    case ($urandom_range(0, 3))
      0: it.compare_line = tracker.line_q;
      1: it.compare_line = tracker.line_q + 8'd1;
      2: it.compare_line = 8'($urandom_range(0, 255));
      default: begin
        case ($urandom_range(0, 3))
          0: it.compare_line = 8'd0;
          1: it.compare_line = 8'(lcdt_pkg::VisibleLines);
          2: it.compare_line = 8'(lcdt_pkg::VisibleLines + lcdt_pkg::VblankLines);
          default: it.compare_line = 8'hff;
        endcase
      end
    endcase
    it.stat_enables = 4'($urandom_range(0, 15));
    return it;
  endfunction

  // Offer one step after a random gap and hold it until accepted.
  task automatic send_step(lcdt_pkg::in_item_t it);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, it};
    do @(posedge clk); while (!in_tready);
    tracker.accept_step(it);
  endtask

  // Receiver: random ready gaps, one long hold-off to back up the pipeline.
  initial begin : result_sink
    int unsigned gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = gaps_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      tracker.compare_result(lcdt_pkg::out_item_t'(out_tdata[21:0]));
      results_seen++;
      if (results_seen == 400) begin
        // Hold off while the sender keeps offering so in_tready must drop.
        out_tready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    lcdt_pkg::in_item_t directed[$];
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, each mode boundary within a line, display off and back on,
    // a line crossing with a large count and an exact wrap at the line end.
    directed.push_back(make_step(8'd0, 1'b1, 8'd0, 4'b1000));
    directed.push_back(make_step(8'd255, 1'b1, 8'hff, 4'b0000));
    directed.push_back(make_step(8'd255, 1'b1, 8'd1, 4'b0001));
    directed.push_back(make_step(8'd255, 1'b0, 8'hff, 4'b1111));
    directed.push_back(make_step(8'd1, 1'b1, 8'd0, 4'b0100));
    directed.push_back(make_step(8'd100, 1'b1, 8'd0, 4'b0010));
    directed.push_back(make_step(8'd128, 1'b1, 8'd0, 4'b0001));
    directed.push_back(make_step(8'd170, 1'b1, 8'd0, 4'b0001));
    directed.push_back(make_step(8'd3, 1'b1, 8'd1, 4'b1000));
    directed.push_back(make_step(8'd79, 1'b1, 8'd1, 4'b0100));
    directed.push_back(make_step(8'd1, 1'b1, 8'd2, 4'b0100));
    directed.push_back(make_step(8'd171, 1'b1, 8'd2, 4'b0001));
    directed.push_back(make_step(8'd1, 1'b1, 8'd2, 4'b0001));
    directed.push_back(make_step(8'haa, 1'b1, 8'h55, 4'b1010));
    directed.push_back(make_step(8'h55, 1'b1, 8'haa, 4'b0101));
    directed.push_back(make_step(8'd0, 1'b0, 8'd0, 4'b0000));
    directed.push_back(make_step(8'd0, 1'b1, 8'd0, 4'b1111));
    directed.push_back(make_step(8'd255, 1'b1, 8'd144, 4'b1111));
    directed.push_back(make_step(8'd255, 1'b1, 8'd154, 4'b0110));
    directed.push_back(make_step(8'd0, 1'b1, 8'd255, 4'b0000));
    foreach (directed[i]) send_step(directed[i]);

    for (int unsigned n = 0; n < RandomSteps; n++) begin
      if (n % 150 == 0) gaps_on = (n % 450 != 300);
      if (n == 700) begin
        // Pause the sender until every queued result has drained.
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_results.size() != 0) @(posedge clk);
      end
      send_step(random_step(n));
    end
    in_tvalid <= 1'b0;

    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("ran %0d steps over %0d frame wraps with %0d display-off steps",
             tracker.steps, tracker.frame_wraps, tracker.off_steps);
    $display("saw %0d render requests, %0d vblank steps, %0d STAT pulses",
             tracker.renders, tracker.vblank_steps, tracker.stat_pulses);
    if (tracker.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
design/lcdt_pkg.sv
design/lcdt_step.sv
design/lcd_line_timing_and_stat_irq_unit.sv
tb/tb_top.sv
